[src/clipped_span_and_box_drawer_assert.svh]
// Assertion macros for the span drawer checker.
// No dependencies; included by the checker module.
`ifndef CLIPPED_SPAN_AND_BOX_DRAWER_ASSERT_SVH
`define CLIPPED_SPAN_AND_BOX_DRAWER_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define CSBD_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CSBD_ASSERT_ANY(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/csbd_pkg.sv]
// Shared types, codes and clipping functions for the span and box drawer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csbd_pkg;

   localparam int DEF_WINDOW_ROWS = 64;
   localparam int DEF_WINDOW_COLS = 256;
   localparam int CLIP_RIGHT_RESET = 255;
   localparam int CLIP_BOTTOM_RESET = 63;

   typedef enum logic [1:0] {
      OP_HLINE = 2'd0,
      OP_VLINE = 2'd1,
      OP_RECT  = 2'd2,
      OP_BOX   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_CLIP_LEFT   = 2'd0,
      REG_CLIP_RIGHT  = 2'd1,
      REG_CLIP_TOP    = 2'd2,
      REG_CLIP_BOTTOM = 2'd3
   } reg_index_type;

   typedef logic signed [13:0] coord_type;

   typedef struct packed {
      logic                valid;
      logic [7:0]          start;
      logic signed [8:0]   len;
   } clip_type;

   typedef struct packed {
      logic                vert;
      logic [7:0]          sx;
      logic [5:0]          sy;
      logic signed [8:0]   len;
   } span_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic pending;
      logic last;
   } dp_status_type;

   function automatic coord_type sext12(input logic [11:0] v);
      return {{2{v[11]}}, v};
   endfunction

   function automatic coord_type zext8(input logic [7:0] v);
      return {6'b0, v};
   endfunction

   function automatic logic in_range(input coord_type c, input coord_type lo,
                                     input coord_type hi);
      return !(c < lo || c > hi);
   endfunction

   // Along-axis clip: right/bottom edge counts as reached at >=.
   function automatic clip_type clip_axis(input coord_type pos, input coord_type len,
                                          input coord_type lo, input coord_type hi);
      coord_type s;
      coord_type e;
      coord_type d;
      clip_type  r;
      r.valid = 1'b1;
      s = pos;
      e = pos + len;
      if (s < lo) begin
         if (e < lo) r.valid = 1'b0;
         s = lo;
      end
      if (s >= hi) begin
         if (e >= hi) r.valid = 1'b0;
         s = hi;
      end
      if (e < lo) e = lo;
      if (e >= hi) e = hi;
      d = e - s;
      r.start = s[7:0];
      r.len = d[8:0];
      return r;
   endfunction

endpackage

`default_nettype wire

[src/csbd_ctrl.sv]
// Controller state machine for the span and box drawer.
// Depends on csbd_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module csbd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output csbd_pkg::dp_cmd_type        cmd,
   input  wire csbd_pkg::dp_status_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               state_in = ST_CALC;
               ready_in = 1'b0;
            end
         end
         ST_CALC: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.pending || (rsp_tready && sts.last)) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready  = ready_ff;
   assign rsp_tvalid  = (state_ff == ST_EMIT) && sts.pending;
   assign cmd.capture = req_tvalid && ready_ff;
   assign cmd.load    = (state_ff == ST_CALC);
   assign cmd.advance = rsp_tvalid && rsp_tready;

endmodule

`default_nettype wire

[src/csbd_datapath.sv]
// Datapath: window registers, command capture, span clipping and span queue.
// Depends on csbd_pkg for types and clipping functions.
`timescale 1ns / 1ps
`default_nettype none

module csbd_datapath #(
   parameter int WINDOW_ROWS = csbd_pkg::DEF_WINDOW_ROWS,
   parameter int WINDOW_COLS = csbd_pkg::DEF_WINDOW_COLS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_wdata,
   input  wire logic [63:0]           req_tdata,
   input  wire logic [1:0]            req_tuser,
   output logic [23:0]                rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire csbd_pkg::dp_cmd_type  cmd,
   output csbd_pkg::dp_status_type    sts
);

   localparam logic [12:0] COL_MAX = 13'(WINDOW_COLS - 1);
   localparam logic [6:0]  ROW_MAX = 7'(WINDOW_ROWS - 1);
   localparam logic [7:0]  RIGHT_RST = (WINDOW_COLS - 1 > csbd_pkg::CLIP_RIGHT_RESET) ?
      8'(csbd_pkg::CLIP_RIGHT_RESET) : 8'(WINDOW_COLS - 1);
   localparam logic [5:0]  BOTTOM_RST = (WINDOW_ROWS - 1 > csbd_pkg::CLIP_BOTTOM_RESET) ?
      6'(csbd_pkg::CLIP_BOTTOM_RESET) : 6'(WINDOW_ROWS - 1);

   // window registers, saturated on write
   logic [7:0] left_ff, right_ff;
   logic [5:0] top_ff, bottom_ff;
   logic [7:0] col_sat;
   logic [5:0] row_sat;

   assign col_sat = ({5'b0, csr_wdata} > COL_MAX) ? COL_MAX[7:0] : csr_wdata;
   assign row_sat = ({1'b0, csr_wdata[5:0]} > ROW_MAX) ? ROW_MAX[5:0] : csr_wdata[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= RIGHT_RST;
         top_ff    <= '0;
         bottom_ff <= BOTTOM_RST;
      end else if (csr_we) begin
         case (csbd_pkg::reg_index_type'(csr_index))
            csbd_pkg::REG_CLIP_LEFT:   left_ff   <= col_sat;
            csbd_pkg::REG_CLIP_RIGHT:  right_ff  <= col_sat;
            csbd_pkg::REG_CLIP_TOP:    top_ff    <= row_sat;
            csbd_pkg::REG_CLIP_BOTTOM: bottom_ff <= row_sat;
            default: ;
         endcase
      end
   end

   // captured command
   csbd_pkg::opcode_type op_ff;
   csbd_pkg::coord_type  xa_ff, ya_ff, xb_ff, yb_ff, ln_ff, dx_ff, dy_ff;
   csbd_pkg::coord_type  xa_in, ya_in, xb_in, yb_in;

   assign xa_in = csbd_pkg::sext12(req_tdata[11:0]);
   assign ya_in = csbd_pkg::sext12(req_tdata[23:12]);
   assign xb_in = csbd_pkg::sext12(req_tdata[35:24]);
   assign yb_in = csbd_pkg::sext12(req_tdata[47:36]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= csbd_pkg::opcode_type'(req_tuser);
         xa_ff <= xa_in;
         ya_ff <= ya_in;
         xb_ff <= xb_in;
         yb_ff <= yb_in;
         ln_ff <= csbd_pkg::sext12(req_tdata[59:48]);
         dx_ff <= xb_in - xa_in;
         dy_ff <= yb_in - ya_in;
      end
   end

   // clipping of all candidate spans
   csbd_pkg::coord_type lft, rgt, top, bot, len0;
   csbd_pkg::clip_type  h0, v0, v1, h2, v3;
   logic                h0_ok, v0_ok, v1_ok, h2_ok, v3_ok;
   csbd_pkg::coord_type first_row, end_row;
   logic                rows_ok;

   assign lft  = csbd_pkg::zext8(left_ff);
   assign rgt  = csbd_pkg::zext8(right_ff);
   assign top  = csbd_pkg::zext8({2'b0, top_ff});
   assign bot  = csbd_pkg::zext8({2'b0, bottom_ff});
   assign len0 = (op_ff == csbd_pkg::OP_HLINE) ? ln_ff : dx_ff;

   assign h0 = csbd_pkg::clip_axis(xa_ff, len0, lft, rgt);
   assign v0 = csbd_pkg::clip_axis(ya_ff, ln_ff, top, bot);
   assign v1 = csbd_pkg::clip_axis(ya_ff, dy_ff, top, bot);
   assign h2 = csbd_pkg::clip_axis(xb_ff, -dx_ff, lft, rgt);
   assign v3 = csbd_pkg::clip_axis(yb_ff, -dy_ff, top, bot);

   assign h0_ok = h0.valid && csbd_pkg::in_range(ya_ff, top, bot);
   assign v0_ok = v0.valid && csbd_pkg::in_range(xa_ff, lft, rgt);
   assign v1_ok = v1.valid && csbd_pkg::in_range(xb_ff, lft, rgt);
   assign h2_ok = h2.valid && csbd_pkg::in_range(yb_ff, top, bot);
   assign v3_ok = v3.valid && csbd_pkg::in_range(xa_ff, lft, rgt);

   // box rows that fall inside the window
   always_comb begin
      if (!dy_ff[13]) begin
         first_row = (ya_ff > top) ? ya_ff : top;
         end_row   = (yb_ff < bot) ? yb_ff : bot;
         rows_ok   = (first_row <= end_row);
      end else begin
         first_row = (ya_ff < bot) ? ya_ff : bot;
         end_row   = (yb_ff > top) ? yb_ff : top;
         rows_ok   = (first_row >= end_row);
      end
   end

   // span queue
   csbd_pkg::span_type spans_ff [4];
   csbd_pkg::span_type spans_in [4];
   logic [3:0]         pend_ff, pend_in;
   logic               box_ff, box_in;
   logic               down_ff, down_in;
   logic [5:0]         row_ff, row_in, end_ff, end_in;
   logic [3:0]         lowbit;
   logic [1:0]         sel;
   csbd_pkg::span_type cur;

   assign lowbit = pend_ff & (~pend_ff + 4'd1);

   always_comb begin
      if (pend_ff[0])      sel = 2'd0;
      else if (pend_ff[1]) sel = 2'd1;
      else if (pend_ff[2]) sel = 2'd2;
      else                 sel = 2'd3;
   end

   always_comb begin
      spans_in = spans_ff;
      pend_in  = pend_ff;
      box_in   = box_ff;
      down_in  = down_ff;
      row_in   = row_ff;
      end_in   = end_ff;
      if (cmd.load) begin
         spans_in[0] = '{1'b0, h0.start, ya_ff[5:0], h0.len};
         spans_in[1] = '{1'b1, xb_ff[7:0], v1.start[5:0], v1.len};
         spans_in[2] = '{1'b0, h2.start, yb_ff[5:0], h2.len};
         spans_in[3] = '{1'b1, xa_ff[7:0], v3.start[5:0], v3.len};
         box_in  = 1'b0;
         down_in = !dy_ff[13];
         row_in  = first_row[5:0];
         end_in  = end_row[5:0];
         case (op_ff)
            csbd_pkg::OP_HLINE: pend_in = {3'b0, h0_ok};
            csbd_pkg::OP_VLINE: begin
               spans_in[0] = '{1'b1, xa_ff[7:0], v0.start[5:0], v0.len};
               pend_in = {3'b0, v0_ok};
            end
            csbd_pkg::OP_RECT:  pend_in = {v3_ok, h2_ok, v1_ok, h0_ok};
            csbd_pkg::OP_BOX: begin
               box_in  = 1'b1;
               pend_in = {3'b0, h0.valid && rows_ok};
            end
            default: pend_in = '0;
         endcase
      end else if (cmd.advance) begin
         if (box_ff) begin
            if (row_ff == end_ff) pend_in = '0;
            else row_in = down_ff ? row_ff + 6'd1 : row_ff - 6'd1;
         end else begin
            pend_in = pend_ff & ~lowbit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         box_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         box_ff  <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      spans_ff <= spans_in;
      down_ff  <= down_in;
      row_ff   <= row_in;
      end_ff   <= end_in;
   end

   always_comb begin
      cur = spans_ff[sel];
      if (box_ff) cur.sy = row_ff;
   end

   assign sts.pending = (pend_ff != 4'd0);
   assign sts.last    = box_ff ? (row_ff == end_ff) : ((pend_ff & ~lowbit) == 4'd0);

   assign rsp_tdata = {1'b0, cur.len, cur.sy, cur.sx};
   assign rsp_tuser = cur.vert;
   assign rsp_tlast = sts.last;

endmodule

`default_nettype wire

[src/clipped_span_and_box_drawer.sv]
// Clipped span and box drawer, top level: one command in, clipped spans out.
// After a command is taken, the controller passes through ST_CALC, where the span queue is loaded,
// and then offers the spans in ST_EMIT, one span per cycle while rsp_tready is high. One command at
// a time is served by the single shared span queue and row walker. The next command is taken the
// cycle after the last span has gone out.
// Reset: synchronous, active high; clears the controller and loads the window defaults.
`timescale 1ns / 1ps
`default_nettype none

module clipped_span_and_box_drawer #(
   parameter int WINDOW_ROWS = csbd_pkg::DEF_WINDOW_ROWS,
   parameter int WINDOW_COLS = csbd_pkg::DEF_WINDOW_COLS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // x_a, y_a, x_b, y_b, span_length, zero pad
   input  wire logic [1:0]  req_tuser,  // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // start_x, start_y, clipped_length, zero pad
   output logic             rsp_tuser,  // is_vertical
   output logic             rsp_tlast
);

   csbd_pkg::dp_cmd_type    cmd;
   csbd_pkg::dp_status_type sts;

   csbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   csbd_datapath #(
      .WINDOW_ROWS (WINDOW_ROWS),
      .WINDOW_COLS (WINDOW_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

[src/csbd_checker.sv]
// Port-level checker for the span and box drawer, bound to the top level.
// Depends on clipped_span_and_box_drawer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_span_and_box_drawer_assert.svh"

module csbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   `CSBD_ASSERT_ANY(a_reset_idle, clock, reset |=> req_tready && !rsp_tvalid, "not idle after reset")

   `CSBD_ASSERT_RST(a_gap_after_req, clock, reset, req_tvalid && req_tready |=> !rsp_tvalid, "span offered in the cycle after a command")

   `CSBD_ASSERT_RST(a_one_cmd, clock, reset, rsp_tvalid |-> !req_tready, "command accepted while spans are pending")

   `CSBD_ASSERT_RST(a_ready_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready, "not ready after last span")

   `CSBD_ASSERT_RST(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled span changed")

endmodule

bind clipped_span_and_box_drawer csbd_checker u_csbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[dv/csbd_span_checker.sv]
// Span checker for the clipped span and box drawer: watches the command, result
// and register channels, predicts the clipped spans and compares each result.
// Depends on csbd_pkg for the opcode and register index codes.
`timescale 1ns / 1ps

module csbd_span_checker #(
   parameter int WINDOW_ROWS = csbd_pkg::DEF_WINDOW_ROWS,
   parameter int WINDOW_COLS = csbd_pkg::DEF_WINDOW_COLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // x_a, y_a, x_b, y_b, span_length, zero pad
   input  logic [1:0]  req_tuser,   // opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // start_x, start_y, clipped_length, zero pad
   input  logic        rsp_tuser,   // is_vertical
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          spans_owed
);

   import csbd_pkg::*;

   localparam int MAX_SPANS = 64;

   typedef struct packed {
      logic       vert;
      logic [7:0] sx;
      logic [5:0] sy;
      logic [8:0] len;
      logic       last;
   } exp_span_type;

   exp_span_type spans_due[$];
   exp_span_type cmd_spans[$];

   int win_left;
   int win_right;
   int win_top;
   int win_bottom;

   function automatic int saturate(input int v, input int lim);
      return (v > lim) ? lim : v;
   endfunction

   // along-axis clip; far edge counts as reached at >=
   function automatic bit clip_run(input int pos, input int len, input int lo, input int hi,
                                   output int s, output int e);
      s = pos;
      e = pos + len;
      if (s < lo) begin
         if (e < lo) return 1'b0;
         s = lo;
      end
      if (s >= hi) begin
         if (e >= hi) return 1'b0;
         s = hi;
      end
      if (e < lo) e = lo;
      if (e >= hi) e = hi;
      return 1'b1;
   endfunction

   function automatic void add_span(input bit vert, input int x, input int y, input int len);
      exp_span_type sp;
      if (cmd_spans.size() >= MAX_SPANS) return;
      sp.vert = vert;
      sp.sx   = 8'(x);
      sp.sy   = 6'(y);
      sp.len  = 9'(len);
      sp.last = 1'b0;
      cmd_spans.push_back(sp);
   endfunction

   function automatic void hspan(input int x, input int y, input int len);
      int s;
      int e;
      if (y < win_top || y > win_bottom) return;
      if (!clip_run(x, len, win_left, win_right, s, e)) return;
      add_span(1'b0, s, y, e - s);
   endfunction

   function automatic void vspan(input int x, input int y, input int len);
      int s;
      int e;
      if (x < win_left || x > win_right) return;
      if (!clip_run(y, len, win_top, win_bottom, s, e)) return;
      add_span(1'b1, x, s, e - s);
   endfunction

   function automatic void draw_command(input opcode_type op, input logic [63:0] fields);
      int xa;
      int ya;
      int xb;
      int yb;
      int ln;
      int len;
      int dy;
      int step;
      int rows;
      int row;
      xa = $signed(fields[11:0]);
      ya = $signed(fields[23:12]);
      xb = $signed(fields[35:24]);
      yb = $signed(fields[47:36]);
      ln = $signed(fields[59:48]);
      cmd_spans.delete();
      case (op)
         OP_HLINE: hspan(xa, ya, ln);
         OP_VLINE: vspan(xa, ya, ln);
         OP_RECT: begin
            hspan(xa, ya, xb - xa);
            vspan(xb, ya, yb - ya);
            hspan(xb, yb, xa - xb);
            vspan(xa, yb, ya - yb);
         end
         default: begin
            len  = xb - xa;
            dy   = yb - ya;
            step = (dy < 0) ? -1 : 1;
            rows = ((dy < 0) ? -dy : dy) + 1;
            row  = ya;
            for (int i = 0; i < rows; i++) begin
               hspan(xa, row, len);
               row += step;
            end
         end
      endcase
      if (cmd_spans.size() > 0) cmd_spans[cmd_spans.size() - 1].last = 1'b1;
      foreach (cmd_spans[i]) spans_due.push_back(cmd_spans[i]);
   endfunction

   always @(posedge clock) begin : watch
      exp_span_type got;
      exp_span_type want;
      if (reset) begin
         win_left   = 0;
         win_right  = saturate(CLIP_RIGHT_RESET, WINDOW_COLS - 1);
         win_top    = 0;
         win_bottom = saturate(CLIP_BOTTOM_RESET, WINDOW_ROWS - 1);
         spans_due.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_CLIP_LEFT:   win_left   = saturate(csr_wdata, WINDOW_COLS - 1);
               REG_CLIP_RIGHT:  win_right  = saturate(csr_wdata, WINDOW_COLS - 1);
               REG_CLIP_TOP:    win_top    = saturate(csr_wdata[5:0], WINDOW_ROWS - 1);
               REG_CLIP_BOTTOM: win_bottom = saturate(csr_wdata[5:0], WINDOW_ROWS - 1);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) draw_command(opcode_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.vert = rsp_tuser;
            got.sx   = rsp_tdata[7:0];
            got.sy   = rsp_tdata[13:8];
            got.len  = rsp_tdata[22:14];
            got.last = rsp_tlast;
            if (spans_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected span: v=%0d x=%0d y=%0d len=%0d last=%0d",
                           got.vert, got.sx, got.sy, $signed(got.len), got.last);
            end else begin
               want = spans_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  // fields: vert, x, y, len, last
                  if (mismatches <= 10)
                     $display("span mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                              want.vert, want.sx, want.sy, $signed(want.len), want.last,
                              got.vert, got.sx, got.sy, $signed(got.len), got.last);
               end
            end
         end
      end
      spans_owed <= spans_due.size();
   end

endmodule

[dv/tb.sv]
// Testbench top for the clipped span and box drawer: drives commands and window
// register writes under several idle and stall mixes, and reports the verdict.
// Depends on csbd_pkg, clipped_span_and_box_drawer and csbd_span_checker.
`timescale 1ns / 1ps

module tb;

   import csbd_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire [23:0]  rsp_tdata;
   wire         rsp_tuser;
   wire         rsp_tlast;

   int span_errors;
   int spans_owed;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   clipped_span_and_box_drawer DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   csbd_span_checker span_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (span_errors),
      .spans_owed (spans_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // holds valid across back-to-back transactions; lowers it only for a gap
   task automatic send_cmd(input opcode_type op, input int xa, input int ya, input int xb,
                           input int yb, input int ln);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, 12'(ln), 12'(yb), 12'(xb), 12'(ya), 12'(xa)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
   endtask

   task automatic send_random();
      opcode_type op;
      int xa;
      int ya;
      int xb;
      int yb;
      int ln;
      op = opcode_type'($urandom_range(3));
      if ($urandom_range(99) < 12) begin
         xa = $urandom_range(4095);
         ya = $urandom_range(4095);
         xb = $urandom_range(4095);
         yb = $urandom_range(4095);
         ln = $urandom_range(4095);
      end else begin
         xa = $urandom_range(300) - 22;
         ya = $urandom_range(90) - 13;
         xb = $urandom_range(300) - 22;
         if (op == OP_BOX && $urandom_range(9) != 0) yb = ya + $urandom_range(16) - 8;
         else yb = $urandom_range(90) - 13;
         ln = $urandom_range(600) - 300;
      end
      send_cmd(op, xa, ya, xb, yb, ln);
   endtask

   // idle point: all spans out, then slack for commands that clip to nothing
   task automatic drain_spans();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (spans_owed != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic put_reg(input reg_index_type idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_window(input int l, input int r, input int t, input int b);
      put_reg(REG_CLIP_LEFT, 8'(l));
      put_reg(REG_CLIP_RIGHT, 8'(r));
      put_reg(REG_CLIP_TOP, 8'(t));
      put_reg(REG_CLIP_BOTTOM, 8'(b));
      csr_we <= 1'b0;
   endtask

   initial begin
      int lft;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset window 0..255 x 0..63
      send_cmd(OP_HLINE, 0, 0, 1234, -77, 255);
      send_cmd(OP_HLINE, -2048, 63, 0, 0, 2047);
      send_cmd(OP_HLINE, 2047, 10, -2048, 2047, -2048);
      send_cmd(OP_HLINE, 5, 64, 0, 0, 20);
      send_cmd(OP_HLINE, 5, -1, 0, 0, 20);
      send_cmd(OP_HLINE, -10, 5, 0, 0, -5);
      send_cmd(OP_HLINE, 255, 5, 0, 0, 5);
      send_cmd(OP_HLINE, 300, 5, 0, 0, -100);
      send_cmd(OP_HLINE, 100, 30, 0, 0, 0);
      send_cmd(OP_VLINE, 0, -2048, 0, 0, 2047);
      send_cmd(OP_VLINE, 255, 63, 0, 0, -63);
      send_cmd(OP_VLINE, 256, 10, 0, 0, 5);
      send_cmd(OP_VLINE, 10, 63, 0, 0, 0);
      send_cmd(OP_RECT, -5, -5, 300, 70, -2048);
      send_cmd(OP_RECT, 10, 10, 200, 50, 2047);
      send_cmd(OP_RECT, 2047, 2047, -2048, -2048, 0);
      send_cmd(OP_BOX, 5, 70, 20, -10, 0);
      send_cmd(OP_BOX, 0, -2048, 255, 2047, 0);
      send_cmd(OP_BOX, 300, 5, 400, 10, 0);
      send_cmd(OP_BOX, -100, 30, -50, 30, 0);
      send_cmd(OP_BOX, 10, 20, -20, 20, 0);

      for (int p = 0; p < 9; p++) begin
         drain_spans();
         case (p % 4)
            0: begin req_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct <= 83; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct <= 0;  rsp_stall_pct <= 83; end
            default: begin req_idle_pct <= 34; rsp_stall_pct <= 34; end
         endcase
         case (p)
            0, 8: set_window(0, 255, 0, 63);
            2, 6: set_window($urandom_range(255, 129), $urandom_range(127),
                             $urandom_range(63, 33) | ($urandom_range(3) << 6),
                             $urandom_range(31));
            3: set_window(0, 0, 0, 0);
            4: set_window(255, 255, 63, 63);
            7: begin
               lft = $urandom_range(200);
               set_window(lft, lft + $urandom_range(40), $urandom_range(40),
                          $urandom_range(63));
            end
            default: set_window($urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(255));
         endcase
         repeat (34) send_random();
      end
      drain_spans();

      if (span_errors == 0 && spans_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/csbd_pkg.sv
src/csbd_ctrl.sv
src/csbd_datapath.sv
src/clipped_span_and_box_drawer.sv
src/csbd_checker.sv
dv/csbd_span_checker.sv
dv/tb.sv
